// File: src/ors_pkg.sv
// Shared types, constants and a helper function for the orbit rotation step core.
`default_nettype none
package ors_pkg;

    localparam int MAX_SLOTS    = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_LEN    = 24;
    localparam int CORDIC_N     = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    localparam int SLOT_W       = $clog2(MAX_SLOTS + 1);

    localparam int ACC_W = 66;   // accumulator / product width
    localparam int OP_W  = 33;   // multiplier operand width
    localparam int XY_W  = 34;   // cordic x, y
    localparam int Z_W   = 34;   // angle register
    localparam int T_W   = 52;   // k*sin >> 14
    localparam int IDX_W = 5;

    localparam logic signed [Z_W-1:0] PI_Q26      = 34'sd210828714;
    localparam logic signed [Z_W-1:0] TWO_PI_Q26  = 34'sd421657428;
    localparam logic signed [Z_W-1:0] HALF_PI_Q26 = 34'sd105414357;
    localparam logic signed [XY_W-1:0] GAIN_Q30   = 34'sd652032874;
    localparam logic signed [ACC_W-1:0] ROUND_Q30 = 66'sd536870912;

    // multiply-accumulate ops
    localparam logic [2:0] MAC_NONE = 3'd0;
    localparam logic [2:0] MAC_SET  = 3'd1;
    localparam logic [2:0] MAC_ADD  = 3'd2;
    localparam logic [2:0] MAC_SUB  = 3'd3;
    localparam logic [2:0] MAC_ADDT = 3'd4;

    // operand A sources
    localparam logic [3:0] A_V0    = 4'd0;
    localparam logic [3:0] A_V1    = 4'd1;
    localparam logic [3:0] A_V2    = 4'd2;
    localparam logic [3:0] A_CM0   = 4'd3;
    localparam logic [3:0] A_CM1   = 4'd4;
    localparam logic [3:0] A_CM2   = 4'd5;
    localparam logic [3:0] A_SPEED = 4'd6;
    localparam logic [3:0] A_CJ1   = 4'd7;
    localparam logic [3:0] A_CJ2   = 4'd8;
    localparam logic [3:0] A_K     = 4'd9;
    localparam logic [3:0] A_UJ    = 4'd10;

    // operand B sources
    localparam logic [3:0] B_P0    = 4'd0;
    localparam logic [3:0] B_P1    = 4'd1;
    localparam logic [3:0] B_P2    = 4'd2;
    localparam logic [3:0] B_V0    = 4'd3;
    localparam logic [3:0] B_V1    = 4'd4;
    localparam logic [3:0] B_V2    = 4'd5;
    localparam logic [3:0] B_CM0   = 4'd6;
    localparam logic [3:0] B_CM1   = 4'd7;
    localparam logic [3:0] B_CM2   = 4'd8;
    localparam logic [3:0] B_TSTEP = 4'd9;
    localparam logic [3:0] B_UJ1   = 4'd10;
    localparam logic [3:0] B_UJ2   = 4'd11;
    localparam logic [3:0] B_SIN   = 4'd12;
    localparam logic [3:0] B_COS   = 4'd13;

    // datapath actions
    localparam logic [3:0] D_NONE  = 4'd0;
    localparam logic [3:0] D_C     = 4'd1;
    localparam logic [3:0] D_SQRT  = 4'd2;
    localparam logic [3:0] D_SPEED = 4'd3;
    localparam logic [3:0] D_CLEN  = 4'd4;
    localparam logic [3:0] D_ANGLE = 4'd5;
    localparam logic [3:0] D_MOD   = 4'd6;
    localparam logic [3:0] D_FOLD  = 4'd7;
    localparam logic [3:0] D_CORD  = 4'd8;
    localparam logic [3:0] D_TRIG  = 4'd9;
    localparam logic [3:0] D_DIV   = 4'd10;
    localparam logic [3:0] D_K     = 4'd11;
    localparam logic [3:0] D_T     = 4'd12;
    localparam logic [3:0] D_OUT   = 4'd13;
    localparam logic [3:0] D_IDENT = 4'd14;

    typedef struct packed {
        logic [2:0]       mac;
        logic [3:0]       asel;
        logic [3:0]       bsel;
        logic [3:0]       dst;
        logic [IDX_W-1:0] idx;
        logic [2:0]       comp;
    } cmd_t;

    typedef struct packed {
        logic c_zero;
        logic mod_done;
        logic sqrt_done;
        logic div_done;
    } status_t;

    typedef struct packed {
        logic in_ready;
        logic emit;
    } hs_t;

    typedef struct packed {
        logic               frame_start;
        logic               detail_level;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic signed [15:0] vel_z;
        logic [13:0]        sphere_radius;
    } in_item_t;

    typedef struct packed {
        logic [3:0]         slot;
        logic               slot_overflow;
        logic signed [15:0] new_pos_x;
        logic signed [15:0] new_pos_y;
        logic signed [15:0] new_pos_z;
        logic signed [15:0] new_vel_x;
        logic signed [15:0] new_vel_y;
        logic signed [15:0] new_vel_z;
        logic [13:0]        out_radius;
    } out_item_t;

    // atan(2^-i) in Q.26
    function automatic logic [25:0] atan_q26(input logic [IDX_W-1:0] i);
        logic [25:0] a;
        case (i)
            5'd0:    a = 26'd52707179;
            5'd1:    a = 26'd31114864;
            5'd2:    a = 26'd16440240;
            5'd3:    a = 26'd8345322;
            5'd4:    a = 26'd4188855;
            5'd5:    a = 26'd2096470;
            5'd6:    a = 26'd1048491;
            5'd7:    a = 26'd524277;
            5'd8:    a = 26'd262143;
            5'd9:    a = 26'd131072;
            5'd10:   a = 26'd65536;
            5'd11:   a = 26'd32768;
            5'd12:   a = 26'd16384;
            5'd13:   a = 26'd8192;
            5'd14:   a = 26'd4096;
            5'd15:   a = 26'd2048;
            5'd16:   a = 26'd1024;
            5'd17:   a = 26'd512;
            5'd18:   a = 26'd256;
            5'd19:   a = 26'd128;
            5'd20:   a = 26'd64;
            5'd21:   a = 26'd32;
            5'd22:   a = 26'd16;
            5'd23:   a = 26'd8;
            default: a = 26'd0;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

// File: src/ors_if.sv
// Valid/ready channel interfaces for sphere items and rotation results.
`default_nettype none
interface ors_in_if;
    logic               valid;
    logic               ready;
    logic               frame_start;
    logic               detail_level;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] vel_z;
    logic [13:0]        sphere_radius;

    modport source (
        output valid, frame_start, detail_level, pos_x, pos_y, pos_z,
               vel_x, vel_y, vel_z, sphere_radius,
        input  ready
    );
    modport sink (
        input  valid, frame_start, detail_level, pos_x, pos_y, pos_z,
               vel_x, vel_y, vel_z, sphere_radius,
        output ready
    );
endinterface

interface ors_out_if;
    logic               valid;
    logic               ready;
    logic [3:0]         slot;
    logic               slot_overflow;
    logic signed [15:0] new_pos_x;
    logic signed [15:0] new_pos_y;
    logic signed [15:0] new_pos_z;
    logic signed [15:0] new_vel_x;
    logic signed [15:0] new_vel_y;
    logic signed [15:0] new_vel_z;
    logic [13:0]        out_radius;

    modport source (
        output valid, slot, slot_overflow, new_pos_x, new_pos_y, new_pos_z,
               new_vel_x, new_vel_y, new_vel_z, out_radius,
        input  ready
    );
    modport sink (
        input  valid, slot, slot_overflow, new_pos_x, new_pos_y, new_pos_z,
               new_vel_x, new_vel_y, new_vel_z, out_radius,
        output ready
    );
endinterface
`default_nettype wire

// File: src/orbit_rotation_step_core.sv
// Top level of the orbit rotation step core: rotates animated spheres about vel x pos.
// Timing: a static sphere is absorbed in its transfer cycle; a zero cross product skips the
// norms and rotation; a rotated result is set by two square roots, six divide/rotate passes
// and up to eight angle-reduction steps.
// Throughput: one sphere at a time; the next transfer is taken once the result is parked.
// Reset (rst_n, async, active low) clears the slot counter, time_step and all handshakes.
`default_nettype none
module orbit_rotation_step_core
    import ors_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    ors_in_if.sink           sphere_in,
    ors_out_if.source        sphere_out,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata
);

    // time_step register: frame time times animation speed, Q4.12
    logic [15:0] tstep_reg, tstep_next;

    // output register: a finished result waits here for its transfer
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_reg, out_next;

    in_item_t    in_item;
    out_item_t   result;
    cmd_t        cmd;
    status_t     status;
    hs_t         hs;
    logic        in_xfer;
    logic        out_free;

    assign in_item.frame_start   = sphere_in.frame_start;
    assign in_item.detail_level  = sphere_in.detail_level;
    assign in_item.pos_x         = sphere_in.pos_x;
    assign in_item.pos_y         = sphere_in.pos_y;
    assign in_item.pos_z         = sphere_in.pos_z;
    assign in_item.vel_x         = sphere_in.vel_x;
    assign in_item.vel_y         = sphere_in.vel_y;
    assign in_item.vel_z         = sphere_in.vel_z;
    assign in_item.sphere_radius = sphere_in.sphere_radius;

    assign sphere_in.ready = hs.in_ready;
    assign in_xfer         = sphere_in.valid && hs.in_ready;

    // the output slot frees up in the same cycle its content is transferred
    assign out_free = !out_valid_reg || sphere_out.ready;

    always_comb
    begin
        tstep_next     = cfg_we ? cfg_wdata : tstep_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && sphere_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (hs.emit)
        begin
            out_next       = result;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tstep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            tstep_reg     <= tstep_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    ors_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sphere_in.valid),
        .in_detail (sphere_in.detail_level),
        .out_free  (out_free),
        .status    (status),
        .cmd       (cmd),
        .hs        (hs)
    );

    ors_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_load (in_xfer),
        .in_item (in_item),
        .tstep   (tstep_reg),
        .cmd     (cmd),
        .status  (status),
        .result  (result)
    );

    assign sphere_out.valid         = out_valid_reg;
    assign sphere_out.slot          = out_reg.slot;
    assign sphere_out.slot_overflow = out_reg.slot_overflow;
    assign sphere_out.new_pos_x     = out_reg.new_pos_x;
    assign sphere_out.new_pos_y     = out_reg.new_pos_y;
    assign sphere_out.new_pos_z     = out_reg.new_pos_z;
    assign sphere_out.new_vel_x     = out_reg.new_vel_x;
    assign sphere_out.new_vel_y     = out_reg.new_vel_y;
    assign sphere_out.new_vel_z     = out_reg.new_vel_z;
    assign sphere_out.out_radius    = out_reg.out_radius;

`ifndef SYNTH
    // a result is never parked over one still waiting for its transfer
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        hs.emit |-> (!out_valid_reg || sphere_out.ready))
        else $error("result emitted into occupied output register");

    // no new sphere is taken while a result is being handed over
    a_ready_emit: assert property (@(posedge clk) disable iff (!rst_n)
        !(hs.in_ready && hs.emit))
        else $error("input ready during emit");

    // output valid only rises after the controller emitted a result
    a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(hs.emit))
        else $error("output valid without emit");
`endif

endmodule
`default_nettype wire

// File: src/ors_isqrt.sv
// Iterative 64-bit integer square root, one result bit per cycle.
`default_nettype none
module ors_isqrt
    import ors_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] radicand,
    output logic             done,
    output logic [31:0]      root
);

    logic [63:0] n_reg, n_next;
    logic [63:0] r_reg, r_next;
    logic [63:0] b_reg, b_next;
    logic        done_reg, done_next;
    logic [64:0] trial;

    assign trial = {1'b0, r_reg} + {1'b0, b_reg};

    always_comb
    begin
        n_next    = n_reg;
        r_next    = r_reg;
        b_next    = b_reg;
        done_next = 1'b0;
        if (start)
        begin
            n_next = radicand;
            r_next = '0;
            b_next = 64'h4000_0000_0000_0000;
        end
        else if (b_reg != '0)
        begin
            if ({1'b0, n_reg} >= trial)
            begin
                n_next = n_reg - trial[63:0];
                r_next = (r_reg >> 1) + b_reg;
            end
            else
            begin
                r_next = r_reg >> 1;
            end
            b_next    = b_reg >> 2;
            done_next = (b_reg == 64'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_reg    <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            b_reg    <= b_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next;
        r_reg <= r_next;
    end

    assign done = done_reg;
    assign root = r_reg[31:0];

endmodule
`default_nettype wire

// File: src/ors_div.sv
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
`default_nettype none
module ors_div
    import ors_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [31:0]      quotient
);

    logic [31:0] rem_reg, rem_next;
    logic [31:0] dq_reg, dq_next;
    logic [31:0] den_reg, den_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;
    logic [32:0] trial;

    assign trial = {rem_reg, dq_reg[31]};

    always_comb
    begin
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            // quotient fits 32 bits, so the high half is below the divisor
            rem_next = dividend[63:32];
            dq_next  = dividend[31:0];
            den_next = divisor;
            cnt_next = 6'd32;
        end
        else if (cnt_reg != '0)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = 32'(trial - {1'b0, den_reg});
                dq_next  = {dq_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = trial[31:0];
                dq_next  = {dq_reg[30:0], 1'b0};
            end
            cnt_next  = cnt_reg - 6'd1;
            done_next = (cnt_reg == 6'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule
`default_nettype wire

// File: src/ors_datapath.sv
// Datapath: operand registers, shared multiply-accumulate, cordic, sqrt and divide units.
`default_nettype none
module ors_datapath
    import ors_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_load,
    input  wire in_item_t    in_item,
    input  wire logic [15:0] tstep,
    input  wire cmd_t        cmd,
    output status_t          status,
    output out_item_t        result
);

    logic signed [15:0]      p_reg [3];
    logic signed [15:0]      p_next [3];
    logic signed [15:0]      v_reg [3];
    logic signed [15:0]      v_next [3];
    logic signed [OP_W-1:0]  c_reg [3];
    logic signed [OP_W-1:0]  c_next [3];
    logic signed [15:0]      res_reg [6];
    logic signed [15:0]      res_next [6];
    logic [13:0]             rad_reg, rad_next;
    logic [3:0]              slot_reg, slot_next;
    logic                    ovf_reg, ovf_next;
    logic [SLOT_W-1:0]       slot_cnt_reg, slot_cnt_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [15:0]             speed_reg, speed_next;
    logic [31:0]             clen_reg, clen_next;
    logic signed [Z_W-1:0]   z_reg, z_next;
    logic                    flip_reg, flip_next;
    logic signed [XY_W-1:0]  x_reg, x_next;
    logic signed [XY_W-1:0]  y_reg, y_next;
    logic signed [OP_W-1:0]  cs_reg, cs_next;
    logic signed [OP_W-1:0]  sn_reg, sn_next;
    logic signed [31:0]      k_reg, k_next;
    logic                    wneg_reg, wneg_next;
    logic signed [T_W-1:0]   t_reg, t_next;

    logic signed [OP_W-1:0]  a_op, b_op, cm [3];
    logic signed [ACC_W-1:0] prod, wabs, rnd, sh;
    logic signed [15:0]      uj, uj1, uj2;
    logic [1:0]              j, j1, j2;
    logic [SLOT_W-1:0]       cnt_n;
    logic signed [Z_W-1:0]   z1, atan_z;
    logic                    sqrt_start, sqrt_done, div_start, div_done;
    logic [31:0]             root, quot;
    logic [63:0]             dividend;

    // component 0..2 rotates the position, 3..5 the velocity
    always_comb
    begin
        case (cmd.comp) inside
            3'd0, 3'd3: j = 2'd0;
            3'd1, 3'd4: j = 2'd1;
            default:    j = 2'd2;
        endcase
        j1  = (j == 2'd2) ? 2'd0 : j + 2'd1;
        j2  = (j == 2'd0) ? 2'd2 : j - 2'd1;
        uj  = (cmd.comp < 3'd3) ? p_reg[j]  : v_reg[j];
        uj1 = (cmd.comp < 3'd3) ? p_reg[j1] : v_reg[j1];
        uj2 = (cmd.comp < 3'd3) ? p_reg[j2] : v_reg[j2];
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            cm[i] = c_reg[i][OP_W-1] ? -c_reg[i] : c_reg[i];
        end
    end

    always_comb
    begin
        unique case (cmd.asel)
            A_V0:    a_op = OP_W'(v_reg[0]);
            A_V1:    a_op = OP_W'(v_reg[1]);
            A_V2:    a_op = OP_W'(v_reg[2]);
            A_CM0:   a_op = cm[0];
            A_CM1:   a_op = cm[1];
            A_CM2:   a_op = cm[2];
            A_SPEED: a_op = $signed({17'd0, speed_reg});
            A_CJ1:   a_op = c_reg[j1];
            A_CJ2:   a_op = c_reg[j2];
            A_K:     a_op = OP_W'(k_reg);
            A_UJ:    a_op = OP_W'(uj);
            default: a_op = '0;
        endcase
        unique case (cmd.bsel)
            B_P0:    b_op = OP_W'(p_reg[0]);
            B_P1:    b_op = OP_W'(p_reg[1]);
            B_P2:    b_op = OP_W'(p_reg[2]);
            B_V0:    b_op = OP_W'(v_reg[0]);
            B_V1:    b_op = OP_W'(v_reg[1]);
            B_V2:    b_op = OP_W'(v_reg[2]);
            B_CM0:   b_op = cm[0];
            B_CM1:   b_op = cm[1];
            B_CM2:   b_op = cm[2];
            B_TSTEP: b_op = $signed({17'd0, tstep});
            B_UJ1:   b_op = OP_W'(uj1);
            B_UJ2:   b_op = OP_W'(uj2);
            B_SIN:   b_op = sn_reg;
            B_COS:   b_op = cs_reg;
            default: b_op = '0;
        endcase
    end

    assign prod   = a_op * b_op;
    assign wabs   = acc_reg[ACC_W-1] ? -acc_reg : acc_reg;
    assign rnd    = acc_reg + ROUND_Q30;
    assign sh     = rnd >>> 30;
    assign atan_z = $signed({8'd0, atan_q26(cmd.idx)});
    assign cnt_n  = in_item.frame_start ? '0 : slot_cnt_reg;
    assign z1     = (z_reg > PI_Q26) ? z_reg - TWO_PI_Q26 : z_reg;
    assign dividend = 64'(wabs <<< 14);

    always_comb
    begin
        p_next        = p_reg;
        v_next        = v_reg;
        c_next        = c_reg;
        res_next      = res_reg;
        rad_next      = rad_reg;
        slot_next     = slot_reg;
        ovf_next      = ovf_reg;
        slot_cnt_next = slot_cnt_reg;
        acc_next      = acc_reg;
        speed_next    = speed_reg;
        clen_next     = clen_reg;
        z_next        = z_reg;
        flip_next     = flip_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        cs_next       = cs_reg;
        sn_next       = sn_reg;
        k_next        = k_reg;
        wneg_next     = wneg_reg;
        t_next        = t_reg;
        sqrt_start    = 1'b0;
        div_start     = 1'b0;

        if (in_load)
        begin
            p_next[0]     = in_item.pos_x;
            p_next[1]     = in_item.pos_y;
            p_next[2]     = in_item.pos_z;
            v_next[0]     = in_item.vel_x;
            v_next[1]     = in_item.vel_y;
            v_next[2]     = in_item.vel_z;
            rad_next      = in_item.sphere_radius;
            slot_cnt_next = cnt_n;
            if (!in_item.detail_level)
            begin
                if (32'(cnt_n) < MAX_SLOTS)
                begin
                    slot_next     = 4'(32'(cnt_n));
                    ovf_next      = 1'b0;
                    slot_cnt_next = cnt_n + 1'b1;
                end
                else
                begin
                    // slots used up: last slot, flagged
                    slot_next = 4'(MAX_SLOTS - 1);
                    ovf_next  = 1'b1;
                end
            end
        end

        case (cmd.mac)
            MAC_SET:  acc_next = prod;
            MAC_ADD:  acc_next = acc_reg + prod;
            MAC_SUB:  acc_next = acc_reg - prod;
            MAC_ADDT: acc_next = acc_reg + ACC_W'(t_reg);
            default:  acc_next = acc_reg;
        endcase

        unique case (cmd.dst)
            D_C:     c_next[cmd.idx[1:0]] = acc_reg[OP_W-1:0];
            D_SQRT:  sqrt_start = 1'b1;
            D_SPEED: speed_next = root[15:0];
            D_CLEN:  clen_next = root;
            D_ANGLE: z_next = acc_reg[Z_W-1:0];
            D_MOD:
            begin
                if (z_reg >= TWO_PI_Q26)
                begin
                    z_next = z_reg - TWO_PI_Q26;
                end
            end
            D_FOLD:
            begin
                x_next = GAIN_Q30;
                y_next = '0;
                if (z1 > HALF_PI_Q26)
                begin
                    z_next    = z1 - PI_Q26;
                    flip_next = 1'b1;
                end
                else if (z1 < -HALF_PI_Q26)
                begin
                    z_next    = z1 + PI_Q26;
                    flip_next = 1'b1;
                end
                else
                begin
                    z_next    = z1;
                    flip_next = 1'b0;
                end
            end
            D_CORD:
            begin
                if (!z_reg[Z_W-1])
                begin
                    x_next = x_reg - (y_reg >>> cmd.idx);
                    y_next = y_reg + (x_reg >>> cmd.idx);
                    z_next = z_reg - atan_z;
                end
                else
                begin
                    x_next = x_reg + (y_reg >>> cmd.idx);
                    y_next = y_reg - (x_reg >>> cmd.idx);
                    z_next = z_reg + atan_z;
                end
            end
            D_TRIG:
            begin
                cs_next = flip_reg ? OP_W'(-x_reg) : OP_W'(x_reg);
                sn_next = flip_reg ? OP_W'(-y_reg) : OP_W'(y_reg);
            end
            D_DIV:
            begin
                div_start = 1'b1;
                wneg_next = acc_reg[ACC_W-1];
            end
            D_K:     k_next = wneg_reg ? -$signed(quot) : $signed(quot);
            D_T:     t_next = T_W'(acc_reg >>> 14);
            D_OUT:
            begin
                if (sh > 66'sd32767)
                begin
                    res_next[cmd.comp] = 16'sh7FFF;
                end
                else if (sh < -66'sd32768)
                begin
                    res_next[cmd.comp] = 16'sh8000;
                end
                else
                begin
                    res_next[cmd.comp] = 16'(sh);
                end
            end
            D_IDENT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    res_next[i]     = p_reg[i];
                    res_next[i + 3] = v_reg[i];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_cnt_reg <= '0;
        end
        else
        begin
            slot_cnt_reg <= slot_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg     <= p_next;
        v_reg     <= v_next;
        c_reg     <= c_next;
        res_reg   <= res_next;
        rad_reg   <= rad_next;
        slot_reg  <= slot_next;
        ovf_reg   <= ovf_next;
        acc_reg   <= acc_next;
        speed_reg <= speed_next;
        clen_reg  <= clen_next;
        z_reg     <= z_next;
        flip_reg  <= flip_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        cs_reg    <= cs_next;
        sn_reg    <= sn_next;
        k_reg     <= k_next;
        wneg_reg  <= wneg_next;
        t_reg     <= t_next;
    end

    ors_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (acc_reg[63:0]),
        .done     (sqrt_done),
        .root     (root)
    );

    ors_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (clen_reg),
        .done     (div_done),
        .quotient (quot)
    );

    assign status.c_zero    = (c_reg[0] == '0) && (c_reg[1] == '0) && (c_reg[2] == '0);
    assign status.mod_done  = (z_reg < TWO_PI_Q26);
    assign status.sqrt_done = sqrt_done;
    assign status.div_done  = div_done;

    assign result.slot          = slot_reg;
    assign result.slot_overflow = ovf_reg;
    assign result.new_pos_x     = res_reg[0];
    assign result.new_pos_y     = res_reg[1];
    assign result.new_pos_z     = res_reg[2];
    assign result.new_vel_x     = res_reg[3];
    assign result.new_vel_y     = res_reg[4];
    assign result.new_vel_z     = res_reg[5];
    assign result.out_radius    = rad_reg;

endmodule
`default_nettype wire

// File: src/ors_ctrl.sv
// Controller: sequences the datapath through cross product, norms, cordic and rotation.
`default_nettype none
module ors_ctrl
    import ors_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    input  wire logic    in_detail,
    input  wire logic    out_free,
    input  wire status_t status,
    output cmd_t         cmd,
    output hs_t          hs
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CROSS = 4'd1;
    localparam logic [3:0] S_ZCHK  = 4'd2;
    localparam logic [3:0] S_SQ    = 4'd3;
    localparam logic [3:0] S_SQW   = 4'd4;
    localparam logic [3:0] S_CSQ   = 4'd5;
    localparam logic [3:0] S_CSQW  = 4'd6;
    localparam logic [3:0] S_ANG   = 4'd7;
    localparam logic [3:0] S_MOD   = 4'd8;
    localparam logic [3:0] S_FOLD  = 4'd9;
    localparam logic [3:0] S_CORD  = 4'd10;
    localparam logic [3:0] S_TRIG  = 4'd11;
    localparam logic [3:0] S_ROT   = 4'd12;
    localparam logic [3:0] S_DIVW  = 4'd13;
    localparam logic [3:0] S_FIN   = 4'd14;
    localparam logic [3:0] S_EMIT  = 4'd15;

    logic [3:0]       state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [2:0]       comp_reg, comp_next;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        comp_next   = comp_reg;
        cmd         = '0;
        cmd.idx     = cnt_reg;
        cmd.comp    = comp_reg;
        hs.in_ready = 1'b0;
        hs.emit     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                hs.in_ready = 1'b1;
                if (in_valid && !in_detail)
                begin
                    state_next = S_CROSS;
                    cnt_next   = '0;
                end
            end
            S_CROSS:
            begin
                cnt_next = cnt_reg + 1'b1;
                case (cnt_reg)
                    5'd0:    begin cmd.mac = MAC_SET; cmd.asel = A_V1; cmd.bsel = B_P2; end
                    5'd1:    begin cmd.mac = MAC_SUB; cmd.asel = A_V2; cmd.bsel = B_P1; end
                    5'd2:    begin cmd.dst = D_C; cmd.idx = 5'd0; end
                    5'd3:    begin cmd.mac = MAC_SET; cmd.asel = A_V2; cmd.bsel = B_P0; end
                    5'd4:    begin cmd.mac = MAC_SUB; cmd.asel = A_V0; cmd.bsel = B_P2; end
                    5'd5:    begin cmd.dst = D_C; cmd.idx = 5'd1; end
                    5'd6:    begin cmd.mac = MAC_SET; cmd.asel = A_V0; cmd.bsel = B_P1; end
                    5'd7:    begin cmd.mac = MAC_SUB; cmd.asel = A_V1; cmd.bsel = B_P0; end
                    default:
                    begin
                        cmd.dst    = D_C;
                        cmd.idx    = 5'd2;
                        state_next = S_ZCHK;
                    end
                endcase
            end
            S_ZCHK:
            begin
                cnt_next = '0;
                if (status.c_zero)
                begin
                    cmd.dst    = D_IDENT;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                cnt_next = cnt_reg + 1'b1;
                case (cnt_reg)
                    5'd0:    begin cmd.mac = MAC_SET; cmd.asel = A_V0; cmd.bsel = B_V0; end
                    5'd1:    begin cmd.mac = MAC_ADD; cmd.asel = A_V1; cmd.bsel = B_V1; end
                    5'd2:    begin cmd.mac = MAC_ADD; cmd.asel = A_V2; cmd.bsel = B_V2; end
                    default: begin cmd.dst = D_SQRT; state_next = S_SQW; end
                endcase
            end
            S_SQW:
            begin
                cnt_next = '0;
                if (status.sqrt_done)
                begin
                    cmd.dst    = D_SPEED;
                    state_next = S_CSQ;
                end
            end
            S_CSQ:
            begin
                cnt_next = cnt_reg + 1'b1;
                case (cnt_reg)
                    5'd0:    begin cmd.mac = MAC_SET; cmd.asel = A_CM0; cmd.bsel = B_CM0; end
                    5'd1:    begin cmd.mac = MAC_ADD; cmd.asel = A_CM1; cmd.bsel = B_CM1; end
                    5'd2:    begin cmd.mac = MAC_ADD; cmd.asel = A_CM2; cmd.bsel = B_CM2; end
                    default: begin cmd.dst = D_SQRT; state_next = S_CSQW; end
                endcase
            end
            S_CSQW:
            begin
                cnt_next = '0;
                if (status.sqrt_done)
                begin
                    cmd.dst    = D_CLEN;
                    state_next = S_ANG;
                end
            end
            S_ANG:
            begin
                if (cnt_reg == '0)
                begin
                    cmd.mac  = MAC_SET;
                    cmd.asel = A_SPEED;
                    cmd.bsel = B_TSTEP;
                    cnt_next = cnt_reg + 1'b1;
                end
                else
                begin
                    cmd.dst    = D_ANGLE;
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                cmd.dst = D_MOD;
                if (status.mod_done)
                begin
                    state_next = S_FOLD;
                end
            end
            S_FOLD:
            begin
                cmd.dst    = D_FOLD;
                cnt_next   = '0;
                state_next = S_CORD;
            end
            S_CORD:
            begin
                cmd.dst = D_CORD;
                if (32'(cnt_reg) == CORDIC_N - 1)
                begin
                    state_next = S_TRIG;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_TRIG:
            begin
                cmd.dst    = D_TRIG;
                cnt_next   = '0;
                comp_next  = '0;
                state_next = S_ROT;
            end
            S_ROT:
            begin
                cnt_next = cnt_reg + 1'b1;
                case (cnt_reg)
                    5'd0:    begin cmd.mac = MAC_SET; cmd.asel = A_CJ1; cmd.bsel = B_UJ2; end
                    5'd1:    begin cmd.mac = MAC_SUB; cmd.asel = A_CJ2; cmd.bsel = B_UJ1; end
                    default: begin cmd.dst = D_DIV; state_next = S_DIVW; end
                endcase
            end
            S_DIVW:
            begin
                cnt_next = '0;
                if (status.div_done)
                begin
                    cmd.dst    = D_K;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cnt_next = cnt_reg + 1'b1;
                case (cnt_reg)
                    5'd0:    begin cmd.mac = MAC_SET; cmd.asel = A_K; cmd.bsel = B_SIN; end
                    5'd1:    cmd.dst = D_T;
                    5'd2:    begin cmd.mac = MAC_SET; cmd.asel = A_UJ; cmd.bsel = B_COS; end
                    5'd3:    cmd.mac = MAC_ADDT;
                    default:
                    begin
                        cmd.dst  = D_OUT;
                        cnt_next = '0;
                        if (comp_reg == 3'd5)
                        begin
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            comp_next  = comp_reg + 3'd1;
                            state_next = S_ROT;
                        end
                    end
                endcase
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    hs.emit    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            comp_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            comp_reg  <= comp_next;
        end
    end

endmodule
`default_nettype wire
